[hdl/epoch_to_utc_date_time_unit_macros.svh]
// Assertion helpers shared by the RTL of the epoch conversion unit.
`ifndef EPOCH_TO_UTC_DATE_TIME_UNIT_MACROS_SVH
`define EPOCH_TO_UTC_DATE_TIME_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETUD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETUD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/etud_pkg.sv]
package etud_pkg;

	localparam int unsigned NUM_STAGES = 10;

	typedef struct packed {
		logic [31:0] utc_seconds;
	} utc_item_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year_two_digit;
	} date_item_t;

	// One load enable per pipeline stage.
	typedef struct packed {
		logic [NUM_STAGES:1] en;
	} stage_ctl_t;

	localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
	localparam logic [19:0] DAYS_PER_ERA = 20'd146097;

	// Reciprocals for exact division by constants: q = (x * M) >> K with
	// K = bits(x) + ceil(log2(d)) and M = ceil(2^K / d).
	localparam int unsigned DAY_SHIFT  = 35;
	localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
	localparam int unsigned HOUR_SHIFT = 29;
	localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam int unsigned MIN_SHIFT  = 18;
	localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam int unsigned Q1460_SHIFT = 29;
	localparam logic [18:0] Q1460_RECIP = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam int unsigned YEAR_SHIFT = 27;
	localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam int unsigned MP_SHIFT   = 19;
	localparam logic [11:0] MP_RECIP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	// Day of the March-based year on which month index mp starts.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/etud_stream_if.sv]
interface etud_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/etud_day_split.sv]
module etud_day_split (
	input  logic                  clk,
	input  etud_pkg::stage_ctl_t  ctl,
	input  logic [31:0]           utc_seconds,
	output logic [16:0]           sod_s3,
	output logic [17:0]           doe_s3
);
	logic [50:0] prod_s1;
	logic [31:0] t_s1;
	logic [15:0] days;
	logic [24:0] dm_s2;
	logic [19:0] z_s2;
	logic [24:0] hi_s2;
	logic [6:0]  lo_s2;
	logic [24:0] diff;
	logic [19:0] era_base;

	// 86400 = 128 * 675, so the low seven bits bypass the division.
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			prod_s1 <= 51'(utc_seconds[31:7]) * 51'(etud_pkg::DAY_RECIP);
			t_s1    <= utc_seconds;
		end
	end

	assign days = prod_s1[etud_pkg::DAY_SHIFT +: 16];

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			dm_s2 <= 25'(days) * 25'd675;
			z_s2  <= 20'(days) + etud_pkg::EPOCH_SHIFT;
			hi_s2 <= t_s1[31:7];
			lo_s2 <= t_s1[6:0];
		end
	end

	assign diff = hi_s2 - dm_s2;

	// The shifted day number spans at most six eras.
	always_comb begin
		priority if (z_s2 >= 20'(5 * etud_pkg::DAYS_PER_ERA))
			era_base = 20'(5 * etud_pkg::DAYS_PER_ERA);
		else if (z_s2 >= 20'(4 * etud_pkg::DAYS_PER_ERA))
			era_base = 20'(4 * etud_pkg::DAYS_PER_ERA);
		else if (z_s2 >= 20'(3 * etud_pkg::DAYS_PER_ERA))
			era_base = 20'(3 * etud_pkg::DAYS_PER_ERA);
		else if (z_s2 >= 20'(2 * etud_pkg::DAYS_PER_ERA))
			era_base = 20'(2 * etud_pkg::DAYS_PER_ERA);
		else if (z_s2 >= etud_pkg::DAYS_PER_ERA) era_base = etud_pkg::DAYS_PER_ERA;
		else era_base = 20'd0;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			sod_s3 <= {diff[9:0], lo_s2};
			doe_s3 <= 18'(z_s2 - era_base);
		end
	end
endmodule

[hdl/etud_clock.sv]
module etud_clock (
	input  logic                  clk,
	input  etud_pkg::stage_ctl_t  ctl,
	input  logic [16:0]           sod_s3,
	output logic [4:0]            hour,
	output logic [5:0]            minute,
	output logic [5:0]            second
);
	logic [34:0] p_hr_s4;
	logic [16:0] sod_s4;
	logic [4:0]  hh;
	logic [4:0]  hh_s5;
	logic [16:0] hm_s5;
	logic [16:0] sod_s5;
	logic [4:0]  hh_s6;
	logic [11:0] rem_s6;
	logic [24:0] p_mi_s7;
	logic [11:0] rem_s7;
	logic [4:0]  hh_s7;
	logic [5:0]  mi;
	logic [11:0] mm_s8;
	logic [5:0]  mi_s8;
	logic [11:0] rem_s8;
	logic [4:0]  hh_s8;
	logic [5:0]  ss_s9;
	logic [5:0]  mi_s9;
	logic [4:0]  hh_s9;
	logic [4:0]  hour_s10;
	logic [5:0]  minute_s10;
	logic [5:0]  second_s10;

	assign hh = p_hr_s4[etud_pkg::HOUR_SHIFT +: 5];
	assign mi = p_mi_s7[etud_pkg::MIN_SHIFT +: 6];

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			p_hr_s4 <= 35'(sod_s3) * 35'(etud_pkg::HOUR_RECIP);
			sod_s4  <= sod_s3;
		end
		if (ctl.en[5]) begin
			hh_s5  <= hh;
			hm_s5  <= 17'(hh) * 17'd3600;
			sod_s5 <= sod_s4;
		end
		if (ctl.en[6]) begin
			rem_s6 <= 12'(sod_s5 - hm_s5);
			hh_s6  <= hh_s5;
		end
		if (ctl.en[7]) begin
			p_mi_s7 <= 25'(rem_s6) * 25'(etud_pkg::MIN_RECIP);
			rem_s7  <= rem_s6;
			hh_s7   <= hh_s6;
		end
		if (ctl.en[8]) begin
			mm_s8  <= 12'(mi) * 12'd60;
			mi_s8  <= mi;
			rem_s8 <= rem_s7;
			hh_s8  <= hh_s7;
		end
		if (ctl.en[9]) begin
			ss_s9 <= 6'(rem_s8 - mm_s8);
			mi_s9 <= mi_s8;
			hh_s9 <= hh_s8;
		end
		if (ctl.en[10]) begin
			hour_s10   <= hh_s9;
			minute_s10 <= mi_s9;
			second_s10 <= ss_s9;
		end
	end

	assign hour   = hour_s10;
	assign minute = minute_s10;
	assign second = second_s10;
endmodule

[hdl/etud_calendar.sv]
module etud_calendar (
	input  logic                  clk,
	input  etud_pkg::stage_ctl_t  ctl,
	input  logic [17:0]           doe_s3,
	output logic [4:0]            day,
	output logic [3:0]            month,
	output logic [6:0]            year_two_digit
);
	logic [36:0] p_q_s4;
	logic [2:0]  c36_s4;
	logic        top_s4;
	logic [17:0] doe_s4;
	logic [17:0] num_s5;
	logic [17:0] doe_s5;
	logic [36:0] p_y_s6;
	logic [17:0] doe_s6;
	logic [8:0]  yoe;
	logic [1:0]  c100;
	logic [17:0] yd_s7;
	logic [8:0]  yoe_s7;
	logic [17:0] doe_s7;
	logic [8:0]  doy_s8;
	logic [8:0]  yoe_s8;
	logic [22:0] p_mp_s9;
	logic [8:0]  doy_s9;
	logic [8:0]  yoe_s9;
	logic [3:0]  mp;
	logic [8:0]  yc;
	logic [8:0]  yy;
	logic [4:0]  day_s10;
	logic [3:0]  month_s10;
	logic [6:0]  year_s10;

	assign yoe  = p_y_s6[etud_pkg::YEAR_SHIFT +: 9];
	assign c100 = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
	assign mp   = p_mp_s9[etud_pkg::MP_SHIFT +: 4];

	// January and February belong to the next civil year; 400 years are a whole
	// number of centuries, so only the year of era matters for the two digits.
	assign yc = yoe_s9 + 9'(mp >= 4'd10);

	always_comb begin
		priority if (yc >= 9'd400) yy = yc - 9'd400;
		else if (yc >= 9'd300) yy = yc - 9'd300;
		else if (yc >= 9'd200) yy = yc - 9'd200;
		else if (yc >= 9'd100) yy = yc - 9'd100;
		else yy = yc;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			p_q_s4 <= 37'(doe_s3) * 37'(etud_pkg::Q1460_RECIP);
			c36_s4 <= 3'(doe_s3 >= 18'd36524) + 3'(doe_s3 >= 18'd73048)
				+ 3'(doe_s3 >= 18'd109572) + 3'(doe_s3 >= 18'd146096);
			top_s4 <= (doe_s3 == 18'd146096);
			doe_s4 <= doe_s3;
		end
		if (ctl.en[5]) begin
			num_s5 <= doe_s4 - 18'(p_q_s4[etud_pkg::Q1460_SHIFT +: 7])
				+ 18'(c36_s4) - 18'(top_s4);
			doe_s5 <= doe_s4;
		end
		if (ctl.en[6]) begin
			p_y_s6 <= 37'(num_s5) * 37'(etud_pkg::YEAR_RECIP);
			doe_s6 <= doe_s5;
		end
		if (ctl.en[7]) begin
			yd_s7  <= 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(c100);
			yoe_s7 <= yoe;
			doe_s7 <= doe_s6;
		end
		if (ctl.en[8]) begin
			doy_s8 <= 9'(doe_s7 - yd_s7);
			yoe_s8 <= yoe_s7;
		end
		if (ctl.en[9]) begin
			p_mp_s9 <= 23'(11'(doy_s8) * 11'd5 + 11'd2) * 23'(etud_pkg::MP_RECIP);
			doy_s9  <= doy_s8;
			yoe_s9  <= yoe_s8;
		end
		if (ctl.en[10]) begin
			day_s10   <= 5'(doy_s9 - etud_pkg::month_start(mp) + 9'd1);
			month_s10 <= (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
			year_s10  <= yy[6:0];
		end
	end

	assign day            = day_s10;
	assign month          = month_s10;
	assign year_two_digit = year_s10;
endmodule

[hdl/epoch_to_utc_date_time_unit.sv]
// Channel   | Dir | Payload                                           | Handshake
// utc_in    | in  | utc_seconds                                       | valid/ready
// date_out  | out | hour, minute, second, day, month, year_two_digit  | valid/ready
//
// Ten register stages: four chained reciprocal divisions on the date path set the depth.
// One transaction per cycle unless the output stalls; a result leaves from the last stage.
// Reset clears only the stage valid bits; the datapath registers need none.
// Each full stage holds while the one after it cannot take its entry, so a stall at the output
// fills empty stages first and input is refused only when all ten are full.
`include "epoch_to_utc_date_time_unit_macros.svh"

module epoch_to_utc_date_time_unit (
	input  logic           clk,
	input  logic           arst_n,
	etud_stream_if.sink    utc_in,
	etud_stream_if.source  date_out
);
	localparam int unsigned N = etud_pkg::NUM_STAGES;

	logic [N:1]           vld_q;
	logic [N+1:1]         rdy;
	etud_pkg::stage_ctl_t ctl;
	logic [16:0]          sod_s3;
	logic [17:0]          doe_s3;
	etud_pkg::date_item_t res;
	logic                 fields_ok;
	logic                 day_ok;

	always_comb begin
		rdy[N+1] = date_out.ready;
		for (int i = N; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign ctl.en       = rdy[N:1];
	assign utc_in.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= utc_in.valid;
			end
			for (int i = 2; i <= N; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	etud_day_split u_day_split (
		.clk         (clk),
		.ctl         (ctl),
		.utc_seconds (utc_in.payload.utc_seconds),
		.sod_s3      (sod_s3),
		.doe_s3      (doe_s3)
	);

	etud_clock u_clock (
		.clk    (clk),
		.ctl    (ctl),
		.sod_s3 (sod_s3),
		.hour   (res.hour),
		.minute (res.minute),
		.second (res.second)
	);

	etud_calendar u_calendar (
		.clk            (clk),
		.ctl            (ctl),
		.doe_s3         (doe_s3),
		.day            (res.day),
		.month          (res.month),
		.year_two_digit (res.year_two_digit)
	);

	assign date_out.valid   = vld_q[N];
	assign date_out.payload = res;

	assign fields_ok = (res.hour <= 5'd23) && (res.minute <= 6'd59) && (res.second <= 6'd59)
		&& (res.day >= 5'd1) && (res.month >= 4'd1) && (res.month <= 4'd12)
		&& (res.year_two_digit <= 7'd99);
	assign day_ok = ((res.month != 4'd2) || (res.day <= 5'd29))
		&& ((res.month != 4'd4 && res.month != 4'd6 && res.month != 4'd9
			&& res.month != 4'd11) || (res.day <= 5'd30));

	`ETUD_ASSERT_IMP(a_fields_in_range, clk, arst_n, date_out.valid, fields_ok, "date or time field out of range")
	`ETUD_ASSERT_IMP(a_day_fits_month, clk, arst_n, date_out.valid, day_ok, "day beyond end of month")
	`ETUD_ASSERT_IMP(a_refuse_only_when_full, clk, arst_n, !utc_in.ready, &vld_q, "input refused with an empty stage")
	`ETUD_ASSERT_NXT(a_full_stays_full, clk, arst_n, !utc_in.ready && !date_out.ready, &vld_q, "stalled pipeline lost an entry")
	`ETUD_ASSERT_IMP(a_out_from_last_stage, clk, arst_n, $rose(date_out.valid), $past(vld_q[N-1]), "result appeared without a predecessor")
endmodule
